// ===== sv/grid_ray_dda_caster_assert.svh =====
// Assertion macros for the grid ray caster
`ifndef GRID_RAY_DDA_CASTER_ASSERT_SVH
`define GRID_RAY_DDA_CASTER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define GRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define GRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/grc_pkg.sv =====
// Package: shared types and constants of the grid ray caster
`default_nettype none
package grc_pkg;
    localparam int DIST_W = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_SPRITE = 2'd2;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [1:0]  cell_kind;
        logic [21:0] pos_x;
        logic [21:0] pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [23:0] wall_dist;
        logic        wall_side;
        logic [5:0]  wall_x;
        logic [5:0]  wall_y;
        logic        sprite_seen;
        logic [23:0] sprite_dist;
        logic        sprite_side;
        logic [5:0]  sprite_x;
        logic [5:0]  sprite_y;
    } res_t;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/grc_stream_if.sv =====
// Valid/ready stream interface
`default_nettype none
interface grc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/grc_ram.sv =====
// Generic single-port write, single-port registered-read RAM
`default_nettype none
module grc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/grc_recip.sv =====
// Restoring divider: floor(2^30 / mag), one quotient bit per cycle
`default_nettype none
module grc_recip (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] mag,
    output logic             done,
    output logic [30:0]      quot
);
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] rem_reg;
    logic [30:0] q_reg;
    logic [15:0] d_reg;
    logic [17:0] trial;
    logic        num_bit;

    assign num_bit = (cnt_reg == 5'd30);
    assign trial = {rem_reg, num_bit} - {2'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'd30;
                rem_reg <= '0;
                d_reg <= mag;
            end
            else if (busy_reg)
            begin
                if (!trial[17])
                begin
                    rem_reg <= trial[16:0];
                    q_reg <= {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[15:0], num_bit};
                    q_reg <= {q_reg[29:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end
    assign quot = q_reg;
endmodule
`default_nettype wire

// ===== sv/grid_ray_dda_caster.sv =====
// Top level: grid ray caster with DDA stepping over a cell map in RAM
// Usage:
//   req (sink) takes one transaction per item: mode 0 writes a map cell,
//   mode 1 casts a ray. res (source) returns one transaction per cast.
//   After reset a clearing pass writes every map cell to empty, one cell a
//   cycle over the map RAM depth (4096 cells by default); req is held not ready.
// Sequence:
//   A write is accepted in S_IDLE and written to the map RAM in the same cycle.
//   A cast runs the x and then the y reciprocal (bit-serial divider shared by
//   both axes), the start distances in S_MULX and S_MULY, then S_STEP and
//   S_READ per DDA step (map RAM read plus check), up to MAX_STEPS steps, and
//   S_DONE to post the result; the stepping loop sets the worst case.
// Stalls:
//   The result waits in an output register while res.ready is low; the
//   next request is accepted meanwhile, and a following cast holds its
//   result until the register is free.
`default_nettype none
`include "grid_ray_dda_caster_assert.svh"
module grid_ray_dda_caster #(
    parameter int MAP_DIM = 64,
    parameter int MAX_STEPS = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    grc_stream_if.sink   req,
    grc_stream_if.source res
);
    import grc_pkg::*;

    localparam int CW = $clog2(MAP_DIM);
    localparam int AW = 2 * CW;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int DEPTH = 1 << AW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_MULX, S_MULY, S_STEP, S_READ, S_DONE
    } state_t;

    state_t state_reg;
    req_t   r_reg;
    logic [AW-1:0] clr_reg;
    logic [DIST_W-1:0] del_x_reg, del_y_reg, sd_x_reg, sd_y_reg, dist_reg;
    logic signed [9:0] cx_reg, cy_reg;
    logic side_reg, status_reg, seen_reg, sp_side_reg;
    logic [DIST_W-1:0] sp_dist_reg;
    logic [5:0] sp_x_reg, sp_y_reg;
    logic [SW-1:0] steps_reg;
    logic out_valid_reg;
    res_t out_reg;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [1:0]  wdata, rdata;
    logic        div_start, div_done;
    logic [15:0] div_mag;
    logic [30:0] div_q;

    grc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_map (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    grc_recip u_recip (
        .clk(clk), .rst_n(rst_n), .start(div_start), .mag(div_mag),
        .done(div_done), .quot(div_q)
    );

    logic signed [16:0] dxs, dys;
    assign dxs = 17'(r_reg.dir_x);
    assign dys = 17'(r_reg.dir_y);

    function automatic logic [15:0] absv(input logic signed [16:0] v);
        logic signed [16:0] a;
        a = v[16] ? -v : v;
        return a[15:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat31(input logic [30:0] q);
        return (q[30:DIST_W] != '0) ? DIST_MAX : q[DIST_W-1:0];
    endfunction

    // delta with the zero-direction rules
    function automatic logic [DIST_W-1:0] delta_sel(input logic [15:0] own,
                                                    input logic [15:0] other,
                                                    input logic [30:0] q);
        logic [DIST_W-1:0] d;
        if (other == '0)
            d = '0;
        else if (own == '0)
            d = DIST_W'(65536);
        else
            d = sat31(q);
        return d;
    endfunction

    function automatic logic [DIST_W-1:0] start_d(input logic [21:0] pos,
                                                  input logic pos_dir,
                                                  input logic [DIST_W-1:0] del);
        logic [16:0] f;
        logic [40:0] p;
        f = pos_dir ? (17'd65536 - {1'b0, pos[15:0]}) : {1'b0, pos[15:0]};
        p = 41'(f) * 41'(del);
        return (p[40:16+DIST_W] != '0) ? DIST_MAX : p[16+DIST_W-1:16];
    endfunction

    logic x_lt;
    logic signed [9:0] nx, ny;
    logic [DIST_W-1:0] step_dist;
    logic out_of_map;
    logic [9:0] dim10;
    assign dim10 = 10'(MAP_DIM);
    assign x_lt = sd_x_reg < sd_y_reg;
    assign nx = x_lt ? (cx_reg + ((dxs > 0) ? 10'sd1 : -10'sd1)) : cx_reg;
    assign ny = x_lt ? cy_reg : (cy_reg + ((dys > 0) ? 10'sd1 : -10'sd1));
    assign step_dist = x_lt ? sd_x_reg : sd_y_reg;
    assign out_of_map = nx[9] || ny[9] || (nx >= $signed(dim10)) || (ny >= $signed(dim10));

    logic can_take;
    assign can_take = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE);

    logic post_res;
    assign post_res = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        we = 1'b0;
        waddr = clr_reg;
        wdata = KIND_EMPTY;
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
        end
        else if (req.valid && can_take && req.payload.mode == MODE_WRITE
                 && 32'(req.payload.cell_x) < MAP_DIM
                 && 32'(req.payload.cell_y) < MAP_DIM)
        begin
            we = 1'b1;
            waddr = {CW'(req.payload.cell_y), CW'(req.payload.cell_x)};
            wdata = req.payload.cell_kind;
        end
    end
    assign raddr = {ny[CW-1:0], nx[CW-1:0]};
    assign div_start = (state_reg == S_IDLE && req.valid && req.payload.mode == MODE_CAST)
                       || (state_reg == S_DIVX && div_done);
    assign div_mag = (state_reg == S_IDLE) ? absv(17'(req.payload.dir_x)) : absv(dys);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (post_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid && req.payload.mode == MODE_CAST)
                    begin
                        r_reg <= req.payload;
                        state_reg <= S_DIVX;
                    end
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        del_x_reg <= delta_sel(absv(dxs), absv(dys), div_q);
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        del_y_reg <= delta_sel(absv(dys), absv(dxs), div_q);
                        state_reg <= S_MULX;
                    end
                end
                S_MULX:
                begin
                    sd_x_reg <= start_d(r_reg.pos_x, dxs > 0, del_x_reg);
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    sd_y_reg <= start_d(r_reg.pos_y, dys > 0, del_y_reg);
                    cx_reg <= 10'(r_reg.pos_x[21:16]);
                    cy_reg <= 10'(r_reg.pos_y[21:16]);
                    dist_reg <= '0;
                    side_reg <= 1'b0;
                    status_reg <= 1'b1;
                    seen_reg <= 1'b0;
                    sp_dist_reg <= '0;
                    sp_side_reg <= 1'b0;
                    sp_x_reg <= '0;
                    sp_y_reg <= '0;
                    steps_reg <= '0;
                    if (32'(r_reg.pos_x[21:16]) < MAP_DIM && 32'(r_reg.pos_y[21:16]) < MAP_DIM)
                        state_reg <= S_STEP;
                    else
                        state_reg <= S_DONE;
                end
                S_STEP:
                begin
                    dist_reg <= step_dist;
                    side_reg <= !x_lt;
                    steps_reg <= steps_reg + SW'(1);
                    if (x_lt)
                        sd_x_reg <= sat_add(sd_x_reg, del_x_reg);
                    else
                        sd_y_reg <= sat_add(sd_y_reg, del_y_reg);
                    if (out_of_map)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cx_reg <= nx;
                        cy_reg <= ny;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (rdata == KIND_WALL)
                    begin
                        status_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (rdata == KIND_SPRITE)
                        begin
                            sp_side_reg <= side_reg;
                            if (!seen_reg)
                            begin
                                seen_reg <= 1'b1;
                                sp_dist_reg <= dist_reg;
                                sp_x_reg <= 6'(cx_reg);
                                sp_y_reg <= 6'(cy_reg);
                            end
                        end
                        state_reg <= (32'(steps_reg) >= MAX_STEPS) ? S_DONE : S_STEP;
                    end
                end
                S_DONE:
                begin
                    if (post_res)
                    begin
                        out_reg <= '{status_reg, dist_reg, side_reg, 6'(cx_reg), 6'(cy_reg),
                                     seen_reg, sp_dist_reg, sp_side_reg, sp_x_reg, sp_y_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid = out_valid_reg;
    assign res.payload = out_reg;

    `GRC_ASSERT_IMP(a_no_req_in_clear, state_reg == S_CLEAR, !req.ready)
    `GRC_ASSERT_NEXT(a_out_hold, out_valid_reg && !res.ready, out_valid_reg)
    `GRC_ASSERT_IMP(a_step_bound, state_reg == S_STEP, 32'(steps_reg) < MAX_STEPS)
endmodule
`default_nettype wire

// ===== tb/grc_ray_checker.sv =====
// Checker: tracks the map, predicts each cast result and compares with the block output
`default_nettype none
module grc_ray_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire grc_pkg::req_t req_payload,
    input  wire logic          res_valid,
    input  wire logic          res_ready,
    input  wire grc_pkg::res_t res_payload,
    output int                 mismatches,
    output int                 outstanding,
    output int                 cast_count,
    output int                 write_count,
    output int                 wall_hits,
    output int                 escapes,
    output int                 sprite_rays
);
    import grc_pkg::*;

    localparam int MAP_DIM   = 64;
    localparam int MAX_STEPS = 128;

    logic [1:0] cell_map [0:MAP_DIM*MAP_DIM-1];
    res_t       expected_rays [$];

    function automatic logic [23:0] clip_dist(input longint v);
        return (v > longint'(DIST_MAX)) ? DIST_MAX : v[23:0];
    endfunction

    function automatic logic [23:0] axis_delta(input int own, input int other);
        longint mag;
        if (other == 0)
            return '0;
        if (own == 0)
            return 24'd65536;
        mag = (own < 0) ? -own : own;
        return clip_dist((longint'(1) << 30) / mag);
    endfunction

    function automatic logic [23:0] first_edge(input logic [21:0] pos, input int dir,
                                               input logic [23:0] delta);
        longint frac;
        longint f;
        frac = pos[15:0];
        f = (dir > 0) ? 65536 - frac : frac;
        return clip_dist((f * longint'(delta)) >>> 16);
    endfunction

    function automatic res_t trace_ray(input req_t r);
        res_t       o;
        int         dx, dy, cx, cy, nx, ny, stx, sty, steps;
        logic [23:0] dlx, dly, sdx, sdy, hit_len;
        logic [1:0] kind;
        dx = r.dir_x;
        dy = r.dir_y;
        cx = r.pos_x[21:16];
        cy = r.pos_y[21:16];
        dlx = axis_delta(dx, dy);
        dly = axis_delta(dy, dx);
        stx = (dx > 0) ? 1 : -1;
        sty = (dy > 0) ? 1 : -1;
        sdx = first_edge(r.pos_x, dx, dlx);
        sdy = first_edge(r.pos_y, dy, dly);
        o = '0;
        o.status = 1'b1;
        hit_len = '0;
        steps = 0;
        if (cx < MAP_DIM && cy < MAP_DIM)
        begin
            while (steps < MAX_STEPS)
            begin
                nx = cx;
                ny = cy;
                if (sdx < sdy)
                begin
                    nx += stx;
                    hit_len = sdx;
                    sdx = clip_dist(longint'(sdx) + longint'(dlx));
                    o.wall_side = 1'b0;
                end
                else
                begin
                    ny += sty;
                    hit_len = sdy;
                    sdy = clip_dist(longint'(sdy) + longint'(dly));
                    o.wall_side = 1'b1;
                end
                steps++;
                if (nx < 0 || ny < 0 || nx >= MAP_DIM || ny >= MAP_DIM)
                    break;
                cx = nx;
                cy = ny;
                kind = cell_map[cy*MAP_DIM + cx];
                if (kind == KIND_WALL)
                begin
                    o.status = 1'b0;
                    break;
                end
                if (kind == KIND_SPRITE)
                begin
                    o.sprite_side = o.wall_side;
                    if (!o.sprite_seen)
                    begin
                        o.sprite_seen = 1'b1;
                        o.sprite_dist = hit_len;
                        o.sprite_x = cx[5:0];
                        o.sprite_y = cy[5:0];
                    end
                end
            end
        end
        o.wall_dist = hit_len;
        o.wall_x = cx[5:0];
        o.wall_y = cy[5:0];
        return o;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h", field, got, want);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        cast_count = 0;
        write_count = 0;
        wall_hits = 0;
        escapes = 0;
        sprite_rays = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_DIM*MAP_DIM; i++)
                cell_map[i] = KIND_EMPTY;
            expected_rays.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (req_payload.mode == MODE_CAST)
                begin
                    expected_rays.push_back(trace_ray(req_payload));
                    cast_count++;
                end
                else
                begin
                    cell_map[int'(req_payload.cell_y)*MAP_DIM + int'(req_payload.cell_x)] =
                        req_payload.cell_kind;
                    write_count++;
                end
            end
            if (res_valid && res_ready)
            begin
                if (expected_rays.size() == 0)
                begin
                    report("result transaction with no cast pending", 1, 0);
                end
                else
                begin
                    e = expected_rays.pop_front();
                    if (res_payload.status != e.status)
                        report("status", res_payload.status, e.status);
                    if (res_payload.wall_dist != e.wall_dist)
                        report("wall_dist", res_payload.wall_dist, e.wall_dist);
                    if (res_payload.wall_side != e.wall_side)
                        report("wall_side", res_payload.wall_side, e.wall_side);
                    if (res_payload.wall_x != e.wall_x)
                        report("wall_x", res_payload.wall_x, e.wall_x);
                    if (res_payload.wall_y != e.wall_y)
                        report("wall_y", res_payload.wall_y, e.wall_y);
                    if (res_payload.sprite_seen != e.sprite_seen)
                        report("sprite_seen", res_payload.sprite_seen, e.sprite_seen);
                    if (res_payload.sprite_dist != e.sprite_dist)
                        report("sprite_dist", res_payload.sprite_dist, e.sprite_dist);
                    if (res_payload.sprite_side != e.sprite_side)
                        report("sprite_side", res_payload.sprite_side, e.sprite_side);
                    if (res_payload.sprite_x != e.sprite_x)
                        report("sprite_x", res_payload.sprite_x, e.sprite_x);
                    if (res_payload.sprite_y != e.sprite_y)
                        report("sprite_y", res_payload.sprite_y, e.sprite_y);
                    if (e.status)
                        escapes++;
                    else
                        wall_hits++;
                    if (e.sprite_seen)
                        sprite_rays++;
                end
            end
            outstanding = expected_rays.size();
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_grid_ray_dda_caster.sv =====
// Testbench top: clock, reset, map writes and ray casts, receiver stalls and verdict
`default_nettype none
module tb_grid_ray_dda_caster;
    import grc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int ITEM_TOTAL = 850;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    int   idle_cycles;
    int   mismatches, outstanding, cast_count, write_count;
    int   wall_hits, escapes, sprite_rays;

    grc_stream_if #(.payload_t(req_t)) req_if ();
    grc_stream_if #(.payload_t(res_t)) res_if ();

    grid_ray_dda_caster DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    grc_ray_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_if.valid),
        .req_ready   (req_if.ready),
        .req_payload (req_if.payload),
        .res_valid   (res_if.valid),
        .res_ready   (res_if.ready),
        .res_payload (res_if.payload),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .cast_count  (cast_count),
        .write_count (write_count),
        .wall_hits   (wall_hits),
        .escapes     (escapes),
        .sprite_rays (sprite_rays)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // result side: random stalls, plus one long hold-off when asked
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            res_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic req_t cell_write(input int x, input int y, input logic [1:0] kind);
        req_t r;
        r = '0;
        r.mode = MODE_WRITE;
        r.cell_x = x[5:0];
        r.cell_y = y[5:0];
        r.cell_kind = kind;
        return r;
    endfunction

    function automatic req_t ray(input logic [21:0] px, input logic [21:0] py,
                                 input logic [15:0] dx, input logic [15:0] dy);
        req_t r;
        r = '0;
        r.mode = MODE_CAST;
        r.pos_x = px;
        r.pos_y = py;
        r.dir_x = dx;
        r.dir_y = dy;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.payload = item;
        forever
        begin
            #1;
            if (req_if.ready)
            begin
                @(negedge clk);
                break;
            end
            @(negedge clk);
        end
    endtask

    function automatic logic [15:0] rand_dir();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return 16'($signed($urandom_range(32768)) - 16384);
        else if (pick < 90)
            return 16'($urandom);
        else
            return '0;
    endfunction

    function automatic req_t rand_item();
        req_t r;
        int   pick;
        logic [1:0] kind;
        if ($urandom_range(99) < 40)
        begin
            pick = $urandom_range(99);
            kind = (pick < 35) ? KIND_EMPTY : (pick < 65) ? KIND_WALL :
                   (pick < 90) ? KIND_SPRITE : 2'd3;
            r = cell_write($urandom_range(63), $urandom_range(63), kind);
            r.pos_x = 22'($urandom);
            r.dir_x = 16'($urandom);
        end
        else
        begin
            r = ray(22'($urandom), 22'($urandom), rand_dir(), rand_dir());
            if ($urandom_range(99) < 10)
                r.dir_x = '0;
            else if ($urandom_range(99) < 10)
                r.dir_y = '0;
            r.cell_x = 6'($urandom);
            r.cell_kind = 2'($urandom);
        end
        return r;
    endfunction

    initial
    begin
        req_t directed [$];
        int   phase;
        int   sent;
        rst_n = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        res_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero direction on an empty map, then with a wall, sprite and kind three above
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd0, 16'sd0));
        directed.push_back(cell_write(5, 2, KIND_WALL));
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd0, 16'sd0));
        directed.push_back(cell_write(5, 4, KIND_SPRITE));
        directed.push_back(cell_write(5, 3, 2'd3));
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd0, 16'sd0));
        directed.push_back(ray(22'h05C000, 22'h05F000, 16'sd0, -16'sd16384));
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd16384, 16'sd0));
        directed.push_back(ray(22'h058000, 22'h058000, -16'sd16384, 16'sd0));
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd0, 16'sd16384));
        directed.push_back(cell_write(63, 63, KIND_WALL));
        directed.push_back(cell_write(0, 0, KIND_WALL));
        directed.push_back(ray(22'h000000, 22'h000000, 16'sd16384, 16'sd16384));
        directed.push_back(ray(22'h3FFFFF, 22'h3FFFFF, -16'sd16384, -16'sd16384));
        directed.push_back(ray(22'h3FFFFF, 22'h000000, -16'sd32768, 16'sd32767));
        directed.push_back(ray(22'h208000, 22'h208000, 16'sd1, -16'sd1));
        directed.push_back(ray(22'h20FFFF, 22'h200001, 16'sd11585, 16'sd11585));
        directed.push_back(cell_write(40, 32, KIND_SPRITE));
        directed.push_back(cell_write(45, 32, KIND_SPRITE));
        directed.push_back(cell_write(50, 32, KIND_WALL));
        directed.push_back(ray(22'h208000, 22'h208000, 16'sd16384, 16'sd3));
        directed.push_back(cell_write(5, 2, KIND_EMPTY));
        directed.push_back(ray(22'h058000, 22'h058000, 16'sd0, 16'sd0));
        foreach (directed[i])
            offer(directed[i]);
        sent = directed.size();

        while (sent < ITEM_TOTAL)
        begin
            phase = (sent / 150) % 4;
            send_idle_pct = (phase == 1) ? 74 : (phase == 3) ? 23 : 0;
            recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 23 : 0;
            if (sent == 420)
                hold_req = 1'b1;
            offer(rand_item());
            sent++;
        end
        req_if.valid = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);

        $display("ran %0d casts and %0d map writes: %0d wall hits, %0d escapes",
                 cast_count, write_count, wall_hits, escapes);
        $display("%0d rays crossed a sprite; long result hold-off applied once",
                 sprite_rays);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/grc_pkg.sv
sv/grc_stream_if.sv
sv/grc_ram.sv
sv/grc_recip.sv
sv/grid_ray_dda_caster.sv
tb/grc_ray_checker.sv
tb/tb_grid_ray_dda_caster.sv
